// ----- hdl/upe_pkg.sv -----
package upe_pkg;

    // character codes
    localparam logic [7:0] CHAR_PCT  = 8'h25;
    localparam logic [7:0] CHAR_TWO  = 8'h32;
    localparam logic [7:0] CHAR_FIVE = 8'h35;
    localparam logic [7:0] CTRL_MAX  = 8'h20;
    localparam logic [7:0] CHAR_DEL  = 8'h7F;

    // command queue geometry
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // output slots of one command
    localparam int NUM_SLOTS = 7;

    // held-byte codes of the front end
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // leading part of a command: nothing, a bare '%', or "%25"
    typedef enum logic [1:0] {
        PRE_NONE = 2'd0,
        PRE_PCT  = 2'd1,
        PRE_ESC  = 2'd2
    } pre_mode_t;

    // main part of a command: nothing, the byte itself, or %XY of the byte
    typedef enum logic [1:0] {
        MAIN_NONE = 2'd0,
        MAIN_LIT  = 2'd1,
        MAIN_ESC  = 2'd2
    } main_mode_t;

    typedef struct packed {
        pre_mode_t  pre;
        logic       dig_en;
        logic [7:0] dig;
        main_mode_t main;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic must_escape(input logic [7:0] b);
        logic esc;
        esc = 1'b0;
        unique case (b)
            8'h22, 8'h3C, 8'h3E, 8'h5C, 8'h5E, 8'h60, 8'h7B, 8'h7C, 8'h7D:
                esc = 1'b1;
            default:
                esc = 1'b0;
        endcase
        return esc || (b <= CTRL_MAX) || (b >= CHAR_DEL);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'b0000, n}) : (8'h37 + {4'b0000, n});
    endfunction

endpackage

// ----- hdl/upe_front.sv -----
module upe_front
    import upe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    input  logic     q_full,
    output logic     cmd_valid,
    output cmd_t     cmd
);

    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_digit_reg, held_digit_next;
    logic       accept;
    logic [7:0] b;
    logic       last;
    logic       fresh_hold;
    main_mode_t fresh_main;

    assign accept = push && !q_full;
    assign b      = item.in_byte;
    assign last   = item.in_last;

    // treatment of the byte when nothing is held before it
    always_comb
    begin
        fresh_hold = (b == CHAR_PCT) && !last;
        if (fresh_hold)
        begin
            fresh_main = MAIN_NONE;
        end
        else if ((b == CHAR_PCT) || must_escape(b))
        begin
            fresh_main = MAIN_ESC;
        end
        else
        begin
            fresh_main = MAIN_LIT;
        end
    end

    // classify the beat against the held bytes
    always_comb
    begin
        cmd             = '0;
        cmd.pre         = PRE_NONE;
        cmd.main        = MAIN_NONE;
        cmd.dig         = held_digit_reg;
        cmd.data        = b;
        cmd.last        = last;
        held_count_next = HELD_NONE;
        held_digit_next = held_digit_reg;
        unique case (held_count_reg)
            HELD_PCT:
            begin
                if (is_hex(b) && !last)
                begin
                    held_count_next = HELD_DIGIT;
                    held_digit_next = b;
                end
                else
                begin
                    cmd.pre         = PRE_ESC;
                    cmd.main        = fresh_main;
                    held_count_next = fresh_hold ? HELD_PCT : HELD_NONE;
                end
            end
            HELD_DIGIT:
            begin
                cmd.dig_en = 1'b1;
                if (is_hex(b))
                begin
                    cmd.pre  = PRE_PCT;
                    cmd.main = MAIN_LIT;
                end
                else
                begin
                    cmd.pre         = PRE_ESC;
                    cmd.main        = fresh_main;
                    held_count_next = fresh_hold ? HELD_PCT : HELD_NONE;
                end
            end
            default:
            begin
                cmd.main        = fresh_main;
                held_count_next = fresh_hold ? HELD_PCT : HELD_NONE;
            end
        endcase
    end

    // only beats that produce output enter the queue
    assign cmd_valid = accept &&
                       ((cmd.pre != PRE_NONE) || cmd.dig_en || (cmd.main != MAIN_NONE));

    // held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= HELD_NONE;
            held_digit_reg <= '0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            held_digit_reg <= held_digit_next;
        end
    end

endmodule

// ----- hdl/upe_cmd_fifo.sv -----
module upe_cmd_fifo
    import upe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  cmd_t         wr_data,
    input  logic         rd_en,
    output cmd_t         rd_data,
    output fifo_status_t status
);

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign status.full  = (cnt_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/upe_back.sv -----
module upe_back
    import upe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         q_data,
    input  fifo_status_t q_status,
    output logic         q_pop,
    input  logic         pop,
    output logic         empty,
    output out_item_t    result
);

    cmd_t                 cur_cmd_reg;
    logic [NUM_SLOTS-1:0] cur_mask_reg;
    logic [NUM_SLOTS-1:0] rest_mask, first_slot, load_mask;
    logic [7:0]           slot_byte [NUM_SLOTS];
    logic [7:0]           sel_byte;
    logic                 out_valid_reg;
    out_item_t            out_reg;
    logic                 active, out_free, advance, need_load, pop_accept;

    assign pop_accept = pop && out_valid_reg;
    assign out_free   = !out_valid_reg || pop_accept;
    assign active     = |cur_mask_reg;
    assign advance    = active && out_free;
    assign rest_mask  = cur_mask_reg & (cur_mask_reg - 1'b1);
    assign first_slot = cur_mask_reg & ~(cur_mask_reg - 1'b1);
    assign need_load  = !active || (advance && (rest_mask == '0));
    assign q_pop      = need_load && !q_status.empty;

    // slots a queued command fills
    always_comb
    begin
        load_mask[0] = (q_data.pre != PRE_NONE);
        load_mask[1] = (q_data.pre == PRE_ESC);
        load_mask[2] = (q_data.pre == PRE_ESC);
        load_mask[3] = q_data.dig_en;
        load_mask[4] = (q_data.main != MAIN_NONE);
        load_mask[5] = (q_data.main == MAIN_ESC);
        load_mask[6] = (q_data.main == MAIN_ESC);
    end

    // byte of each slot of the current command
    always_comb
    begin
        slot_byte[0] = CHAR_PCT;
        slot_byte[1] = CHAR_TWO;
        slot_byte[2] = CHAR_FIVE;
        slot_byte[3] = cur_cmd_reg.dig;
        slot_byte[4] = (cur_cmd_reg.main == MAIN_LIT) ? cur_cmd_reg.data : CHAR_PCT;
        slot_byte[5] = hex_char(cur_cmd_reg.data[7:4]);
        slot_byte[6] = hex_char(cur_cmd_reg.data[3:0]);
    end

    // pick the lowest pending slot
    always_comb
    begin
        sel_byte = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sel_byte = sel_byte | (slot_byte[i] & {8{first_slot[i]}});
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg <= '0;
        end
        else if (q_pop)
        begin
            cur_mask_reg <= load_mask;
        end
        else if (advance)
        begin
            cur_mask_reg <= rest_mask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_cmd_reg <= q_data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_byte <= sel_byte;
            out_reg.out_last <= cur_cmd_reg.last && (rest_mask == '0);
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

// ----- hdl/url_percent_encoder_unit.sv -----
// Streaming URL percent-encoder. Each input beat (one byte, with a flag on the
// last byte of the string) is taken whenever full is low: the front end
// classifies it against a held '%' and hex digit and writes at most one command
// into a four-entry queue. The back end expands each command into one to seven
// output bytes, one per cycle through an output register while it is popped,
// so the sustained rate is set by that sequencer: one output byte for a byte that
// passes through, three for an escaped byte, up to seven for a beat that flushes
// a held '%' and digit. A '%' and the hex digit after it, unless last, produce
// nothing until the next byte decides their fate. The first byte of a beat
// reaches the result ports through the queue, the command and output registers.
module url_percent_encoder_unit
    import upe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    logic         cmd_valid;
    cmd_t         cmd;
    cmd_t         q_data;
    fifo_status_t q_status;
    logic         q_pop;

    assign full = q_status.full;

    upe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .q_full    (q_status.full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    upe_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    upe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_status (q_status),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

// ----- hdl/upe_checker.sv -----
module upe_checker
    import upe_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input in_item_t  item,
    input logic      pop,
    input logic      empty,
    input out_item_t result
);

    // an accepted input beat carries known data
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown(item))
    else $error("unknown input beat accepted");

    // a waiting result beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result beat changed before pop");

    // encoded output never carries a control byte, a space or a byte at or above DEL
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.out_byte > CTRL_MAX) && (result.out_byte < CHAR_DEL)))
    else $error("unescaped control or high byte on output");

    // a '%' on the output is never the last byte of its string
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.out_byte == CHAR_PCT)) |-> !result.out_last)
    else $error("string ends on a bare percent");

endmodule

bind url_percent_encoder_unit upe_checker u_upe_checker (.*);
